// ===== design/wios_pkg.sv =====
`default_nettype none
package wios_pkg;

    localparam int unsigned NUM_CORES_DEF = 8;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned CORE_W        = 3;
    localparam int unsigned AFF_W         = 40;
    localparam int unsigned IN_TDATA_W    = 48;
    localparam int unsigned OUT_TDATA_W   = 48;

    localparam logic [AFF_W-1:0] AFF_INVALID = 40'h00_0000_DEAD;

    typedef enum logic [CMD_W-1:0] {
        CMD_WAKEUP  = 2'd0,
        CMD_HOTPLUG = 2'd1,
        CMD_SUSPEND = 2'd2,
        CMD_OTHER   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              route;
        logic [CORE_W-1:0] core;
        logic              unknown;
        logic              nofb;
    } t_dec;

    function automatic logic [CORE_W-1:0] lowest_set(input logic [7:0] m);
        logic [CORE_W-1:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                idx = CORE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== design/wios_ctrl.sv =====
`default_nettype none
module wios_ctrl #(
    parameter int unsigned NUM_CORES = wios_pkg::NUM_CORES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [wios_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [wios_pkg::CORE_W-1:0] i_core,
    input  wire logic [wios_pkg::AFF_W-1:0]  i_aff,
    output wios_pkg::t_dec                 o_dec,
    output logic                           o_wr_en
);
    import wios_pkg::*;

    localparam int unsigned CNT_W = CORE_W + 1;

    logic [NUM_CORES-1:0] r_online, n_online;
    logic [NUM_CORES-1:0] r_intr, n_intr;
    logic [NUM_CORES-1:0] r_marker, n_marker;
    logic [CORE_W-1:0]    r_owner, n_owner;

    logic                 in_range;
    logic [NUM_CORES-1:0] bitv;
    logic                 is_owner;
    logic                 many_online;
    logic [7:0]           online8;
    logic [7:0]           intr8;
    logic [7:0]           marker8;
    logic                 route;
    logic                 nofb;
    logic [CORE_W-1:0]    tgt;

    assign in_range    = {1'b0, i_core} < CNT_W'(NUM_CORES);
    assign bitv        = in_range ? (NUM_CORES'(1) << i_core) : '0;
    assign is_owner    = (r_owner == i_core);
    assign many_online = |(r_online & (r_online - NUM_CORES'(1)));
    assign o_wr_en     = in_range && ((r_marker & bitv) != '0);

    always_comb begin
        n_marker = r_marker;
        if (o_wr_en) begin
            n_marker = (r_marker & ~bitv) | (bitv & {NUM_CORES{i_aff == AFF_INVALID}});
        end
    end

    always_comb begin
        n_online = r_online;
        n_intr   = r_intr;
        route    = 1'b0;
        nofb     = 1'b0;
        tgt      = '0;
        if (in_range) begin
            case (t_cmd'(i_cmd))
                CMD_WAKEUP: begin
                    n_intr   = r_intr | bitv;
                    n_online = r_online | bitv;
                    if (!online8[r_owner]) begin
                        route = 1'b1;
                        tgt   = i_core;
                    end
                end
                CMD_HOTPLUG: begin
                    n_intr   = r_intr & ~bitv;
                    n_online = r_online & ~bitv;
                    if (is_owner) begin
                        if (many_online) begin
                            route = 1'b1;
                            tgt   = lowest_set(online8);
                        end else if (n_intr != '0) begin
                            route = 1'b1;
                            tgt   = lowest_set(intr8);
                        end else begin
                            nofb = 1'b1;
                        end
                    end
                end
                CMD_SUSPEND: begin
                    n_online = r_online & ~bitv;
                    if (is_owner && many_online) begin
                        route = 1'b1;
                        tgt   = lowest_set(online8);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign online8 = 8'(n_online);
    assign intr8   = 8'(n_intr);
    assign marker8 = 8'(n_marker);
    assign n_owner = route ? tgt : r_owner;

    always_comb begin
        o_dec.route   = route;
        o_dec.core    = tgt;
        o_dec.unknown = route && marker8[tgt];
        o_dec.nofb    = nofb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online <= '0;
            r_intr   <= '0;
            r_marker <= '1;
            r_owner  <= '0;
        end else if (i_step) begin
            r_online <= n_online;
            r_intr   <= n_intr;
            r_marker <= n_marker;
            r_owner  <= n_owner;
        end
    end

endmodule
`default_nettype wire

// ===== design/wios_aff_ram.sv =====
`default_nettype none
module wios_aff_ram #(
    parameter int unsigned DEPTH = wios_pkg::NUM_CORES_DEF,
    parameter int unsigned AW    = 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [wios_pkg::AFF_W-1:0] i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic [wios_pkg::AFF_W-1:0]      o_rd_data
);
    import wios_pkg::*;

    logic [AFF_W-1:0] r_mem [DEPTH];
    logic [AFF_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-through when reading the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= i_wr_data;
            end else begin
                r_q <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q;

endmodule
`default_nettype wire

// ===== design/watchdog_irq_owner_selector.sv =====
// channel  | dir | signals                     | word
// s_axis   | in  | tvalid tready tdata[47:0]   | cmd, core_index, core_affinity
// m_axis   | out | tvalid tready tdata[47:0]   | route_valid, route_core,
//          |     |                             | route_affinity, affinity_unknown,
//          |     |                             | no_fallback
//
// one word per cycle sustained while m_axis is ready; a taken word shows on m_axis
// after the input register, then the result register with the affinity ram read
// i_rst_n is synchronous, active low; clears masks, owner and valids and
// marks every affinity entry unknown
// a stalled m_axis holds its word; s_axis keeps accepting while the result
// register drains, and stops only when both stages hold words
`default_nettype none
module watchdog_irq_owner_selector #(
    parameter int unsigned NUM_CORES = wios_pkg::NUM_CORES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cmd[1:0], core_index[4:2], core_affinity[44:5], zero[47:45]
    input  wire logic [wios_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // route_valid[0], route_core[3:1], route_affinity[43:4],
    // affinity_unknown[44], no_fallback[45], zero[47:46]
    output logic [wios_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import wios_pkg::*;

    localparam int unsigned AW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [CORE_W-1:0] r_core;
    logic [AFF_W-1:0]  r_aff;

    logic              r_out_valid;
    t_dec              r_dec;

    logic              adv;
    logic              step;
    t_dec              dec;
    logic              wr_en;
    logic [AFF_W-1:0]  rd_data;
    logic [AFF_W-1:0]  route_aff;

    assign adv           = !r_out_valid || m_axis_tready;
    assign step          = adv && r_in_valid;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd  <= s_axis_tdata[1:0];
            r_core <= s_axis_tdata[4:2];
            r_aff  <= s_axis_tdata[44:5];
        end
    end

    wios_ctrl #(
        .NUM_CORES(NUM_CORES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (r_cmd),
        .i_core  (r_core),
        .i_aff   (r_aff),
        .o_dec   (dec),
        .o_wr_en (wr_en)
    );

    wios_aff_ram #(
        .DEPTH(NUM_CORES),
        .AW   (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (step && wr_en),
        .i_wr_addr (r_core[AW-1:0]),
        .i_wr_data (r_aff),
        .i_rd_en   (step),
        .i_rd_addr (dec.core[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_dec <= dec;
        end
    end

    // an entry still holding the marker may never have been written
    always_comb begin
        route_aff = '0;
        if (r_dec.route) begin
            route_aff = r_dec.unknown ? AFF_INVALID : rd_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_dec.nofb, r_dec.unknown, route_aff,
                            r_dec.core, r_dec.route};

endmodule
`default_nettype wire

// ===== design/wios_checker.sv =====
`default_nettype none
module wios_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic [47:0] i_s_tdata,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [47:0] i_m_tdata
);
    import wios_pkg::*;

    logic s_fire;
    assign s_fire = i_s_tvalid && i_s_tready;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result word changed under stall");

    // no reroute means zero core, affinity and unknown flag
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[0] |-> i_m_tdata[44:1] == 44'd0)
        else $error("fields set without reroute");

    a_nofb_noroute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[45] |-> !i_m_tdata[0])
        else $error("no_fallback with reroute");

    a_unknown_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[44] |-> i_m_tdata[43:4] == AFF_INVALID)
        else $error("unknown owner without marker affinity");

    // an accepted word on an empty pipe passes the input register before it can show
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid && !$past(s_fire) && s_fire |=> !i_m_tvalid)
        else $error("result appeared too early");

endmodule

bind watchdog_irq_owner_selector wios_checker u_wios_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tdata  (s_axis_tdata),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
`default_nettype wire
